/* rtl/yuvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared types and constants for the decimating YCbCr to BGR converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

    // largest frame dimension in pixels
    localparam int MAX_DIM    = 4096;
    // column and row counter width
    localparam int CNT_W      = $clog2(MAX_DIM);
    // register field widths
    localparam int DIM_W      = 13;
    localparam int SCALE_W    = 4;
    localparam int PIX_W      = 8;
    // one phase counter per encodable scale value
    localparam int NUM_PHASE  = 1 << SCALE_W;
    // compare width that holds both a register value and MAX_DIM plus a scale step
    localparam int WIDE_W     = (DIM_W > CNT_W + 1) ? DIM_W + 1 : CNT_W + 2;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = DIM_W'(480);
    localparam logic [SCALE_W-1:0] SCALE_RST        = SCALE_W'(1);

    // register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SCALE        = 2'd2
    } t_reg_idx;

    // one input pixel
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] chroma_v;
    } t_ycc;

    // one converted pixel
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_bgr;

    // raster position decision for the current pixel
    typedef struct packed {
        logic keep;
        logic last;
    } t_raster_info;

endpackage

/* rtl/yuvrgb_raster.sv */
// ----------------------------------------------------------------------------
// yuvrgb_raster
// Column and row tracking, decimation keep decision and end of frame flag.
// ----------------------------------------------------------------------------
module yuvrgb_raster import yuvrgb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [DIM_W-1:0]   i_frame_width,
    input  logic [DIM_W-1:0]   i_frame_height,
    input  logic [SCALE_W-1:0] i_scale,
    output t_raster_info       o_info
);

    // zero means one, oversize clamps to the largest frame
    function automatic logic [WIDE_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [WIDE_W-1:0] vx;
        vx = WIDE_W'(v);
        if (v == '0) begin
            return WIDE_W'(1);
        end else if (vx > WIDE_W'(MAX_DIM)) begin
            return WIDE_W'(MAX_DIM);
        end
        return vx;
    endfunction

    logic [CNT_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_row;
    logic [CNT_W-1:0]   n_col;
    logic [CNT_W-1:0]   n_row;
    logic [SCALE_W-1:0] r_col_phase [NUM_PHASE];
    logic [SCALE_W-1:0] r_row_phase [NUM_PHASE];
    logic [WIDE_W-1:0]  eff_w;
    logic [WIDE_W-1:0]  eff_h;
    logic [WIDE_W-1:0]  col_ext;
    logic [WIDE_W-1:0]  row_ext;
    logic [WIDE_W-1:0]  step_ext;
    logic               col_wrap;
    logic               row_wrap;
    logic               col_last;
    logic               row_last;

    // effective sizes
    assign eff_w    = eff_dim(i_frame_width);
    assign eff_h    = eff_dim(i_frame_height);
    assign col_ext  = WIDE_W'(r_col);
    assign row_ext  = WIDE_W'(r_row);
    assign step_ext = (i_scale == '0) ? WIDE_W'(1) : WIDE_W'(i_scale);

    // end of row and end of frame
    assign col_wrap = (col_ext + WIDE_W'(1)) >= eff_w;
    assign row_wrap = (row_ext + WIDE_W'(1)) >= eff_h;

    // next counter values
    always_comb begin
        n_col = r_col + CNT_W'(1);
        n_row = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : r_row + CNT_W'(1);
        end
    end

    // column and row counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // one phase counter per scale value: position modulo that scale
    for (genvar k = 0; k < NUM_PHASE; k++) begin : g_phase
        localparam logic [SCALE_W-1:0] PHASE_LAST = (k <= 1) ? '0 : SCALE_W'(k - 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_col_phase[k] <= '0;
                r_row_phase[k] <= '0;
            end else if (i_advance) begin
                if (col_wrap) begin
                    r_col_phase[k] <= '0;
                    if (row_wrap || r_row_phase[k] >= PHASE_LAST) begin
                        r_row_phase[k] <= '0;
                    end else begin
                        r_row_phase[k] <= r_row_phase[k] + SCALE_W'(1);
                    end
                end else if (r_col_phase[k] >= PHASE_LAST) begin
                    r_col_phase[k] <= '0;
                end else begin
                    r_col_phase[k] <= r_col_phase[k] + SCALE_W'(1);
                end
            end
        end
    end

    // a kept position is the last one when the next kept step leaves the frame
    assign col_last = (col_ext < eff_w) && ((col_ext + step_ext) >= eff_w);
    assign row_last = (row_ext < eff_h) && ((row_ext + step_ext) >= eff_h);

    assign o_info.keep = (r_col_phase[i_scale] == '0) && (r_row_phase[i_scale] == '0);
    assign o_info.last = col_last && row_last;

endmodule

/* rtl/yuvrgb_csc.sv */
// ----------------------------------------------------------------------------
// yuvrgb_csc
// BT.601 YCbCr to BGR color conversion with Q10 coefficients and clamping.
// ----------------------------------------------------------------------------
module yuvrgb_csc import yuvrgb_pkg::*; (
    input  t_ycc i_pix,
    output t_bgr o_bgr
);

    localparam int SUM_W = 21;
    localparam int FRAC  = 10;

    // floor to integer and clamp to 0..255
    function automatic logic [PIX_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-FRAC-1:0] q;
        q = s[SUM_W-1:FRAC];
        if (s[SUM_W-1]) begin
            return '0;
        end else if (q > (SUM_W-FRAC)'(255)) begin
            return PIX_W'(255);
        end
        return q[PIX_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] c_val;
    logic signed [SUM_W-1:0] d_val;
    logic signed [SUM_W-1:0] e_val;
    logic signed [SUM_W-1:0] yc;
    logic signed [SUM_W-1:0] sum_b;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_r;

    // offset removal
    assign c_val = signed'(SUM_W'(i_pix.luma))     - SUM_W'(signed'(16));
    assign d_val = signed'(SUM_W'(i_pix.chroma_u)) - SUM_W'(signed'(128));
    assign e_val = signed'(SUM_W'(i_pix.chroma_v)) - SUM_W'(signed'(128));

    // constant multiplies and sums
    assign yc    = c_val * SUM_W'(signed'(1192));
    assign sum_b = yc + d_val * SUM_W'(signed'(2066));
    assign sum_g = yc - e_val * SUM_W'(signed'(833)) - d_val * SUM_W'(signed'(400));
    assign sum_r = yc + e_val * SUM_W'(signed'(1634));

    assign o_bgr.blue  = to_byte(sum_b);
    assign o_bgr.green = to_byte(sum_g);
    assign o_bgr.red   = to_byte(sum_r);

endmodule

/* rtl/yuv_to_rgb_decimating_converter.sv */
// ----------------------------------------------------------------------------
// yuv_to_rgb_decimating_converter
// Decimating BT.601 YCbCr to BGR converter for a raster camera stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock (luma plus its block's U/V pair) in raster order
// and emits a BGR pixel for every position whose column and row are both
// multiples of scale; end_of_frame marks the last kept pixel of a frame.
// A request is accepted in every cycle the output side does not stall; a kept
// pixel passes through the input register, then the result register around
// the color multiplies and clamp. Width, height and scale are written through
// the APB port at byte addresses 0, 4 and 8; the user must write them only
// while the stream is idle, which the block does not enforce. A width or height
// of 0 counts as 1, above 4096 counts as 4096, and a scale of 0 counts as 1.
module yuv_to_rgb_decimating_converter import yuvrgb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_luma,
    input  logic [PIX_W-1:0]      i_chroma_u,
    input  logic [PIX_W-1:0]      i_chroma_v,
    // output stream
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_blue,
    output logic [PIX_W-1:0]      o_green,
    output logic [PIX_W-1:0]      o_red,
    output logic                  o_end_of_frame,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [SCALE_W-1:0] r_scale;
    t_reg_idx           reg_idx;
    logic               cfg_write;

    logic               r_s1_valid;
    t_ycc               r_s1_pix;
    logic               r_s1_last;
    logic               r_out_valid;
    t_bgr               r_out_bgr;
    logic               r_out_eof;

    logic               out_ready;
    logic               s1_ready;
    logic               in_accept;
    t_raster_info       raster_info;
    t_bgr               csc_bgr;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_scale        <= SCALE_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                REG_SCALE:        r_scale        <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            REG_SCALE:        prdata = APB_DATA_W'(r_scale);
            default:          prdata = '0;
        endcase
    end

    // pipeline flow control
    assign out_ready = !r_out_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_stall   = !s1_ready;
    assign in_accept = i_valid && s1_ready;

    // raster position tracking
    yuvrgb_raster u_raster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (in_accept),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_scale        (r_scale),
        .o_info         (raster_info)
    );

    // input register; only kept pixels mark it valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= in_accept && raster_info.keep;
        end
        if (s1_ready) begin
            r_s1_pix.luma     <= i_luma;
            r_s1_pix.chroma_u <= i_chroma_u;
            r_s1_pix.chroma_v <= i_chroma_v;
            r_s1_last         <= raster_info.last;
        end
    end

    // color conversion
    yuvrgb_csc u_csc (
        .i_pix (r_s1_pix),
        .o_bgr (csc_bgr)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
        if (out_ready && r_s1_valid) begin
            r_out_bgr <= csc_bgr;
            r_out_eof <= r_s1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_blue         = r_out_bgr.blue;
    assign o_green        = r_out_bgr.green;
    assign o_red          = r_out_bgr.red;
    assign o_end_of_frame = r_out_eof;

`ifndef SYNTHESIS
    // stall only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled without a full pipeline");

    // an accepted pixel fills the input stage exactly when it is kept
    a_keep_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_s1_valid == $past(raster_info.keep)))
        else $error("input stage load does not match keep decision");

    // a full input stage moves into the result register when it can
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_ready) |=> r_out_valid)
        else $error("kept pixel lost between stages");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule
